FILE: hw/rtl/lrast_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lrast_pkg;

   // Default coordinate width; the endpoint fields carry one extra sign bit.
   localparam int unsigned COORD_WIDTH_DEFAULT = 12;
   localparam int unsigned COLOR_WIDTH         = 16;
   localparam int unsigned OFFSET_WIDTH        = 25;

   // Register values after reset.
   localparam int unsigned MAX_COL_RESET    = 639;
   localparam int unsigned MAX_ROW_RESET    = 479;
   localparam int unsigned ROW_STRIDE_RESET = 640;

   localparam int unsigned CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAX_COL    = 2'd0,
      CSR_MAX_ROW    = 2'd1,
      CSR_ROW_STRIDE = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_TICK  = 1'b1
   } kind_type;

   // Signed step along one axis: -1, 0 or +1.
   typedef logic signed [1:0] step_type;

   localparam step_type STEP_NEG  = 2'sb11;
   localparam step_type STEP_ZERO = 2'sb00;
   localparam step_type STEP_POS  = 2'sb01;

   // Rounds a bit count up to whole bytes.
   function automatic int unsigned pad_to_bytes(input int unsigned bits);
      pad_to_bytes = ((bits + 7) / 8) * 8;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lrast_out_queue.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-entry result queue: a head register that drives the outputs and a skid
// register behind it, so that the producer sees a registered ready.
module lrast_out_queue #(
   parameter int unsigned DATA_WIDTH = 8
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire logic [DATA_WIDTH-1:0] push_data,
   output logic                       push_ready,
   output logic                       pop_valid,
   input  wire logic                  pop_ready,
   output logic [DATA_WIDTH-1:0]      pop_data
);

   localparam logic [1:0] COUNT_EMPTY = 2'd0;
   localparam logic [1:0] COUNT_ONE   = 2'd1;
   localparam logic [1:0] COUNT_FULL  = 2'd2;

   logic [1:0]            count_ff;
   logic [1:0]            count_in;
   logic [DATA_WIDTH-1:0] head_ff;
   logic [DATA_WIDTH-1:0] skid_ff;
   logic                  push;
   logic                  pop;
   logic                  head_from_push;
   logic                  head_from_skid;
   logic                  skid_from_push;

   assign push_ready = (count_ff != COUNT_FULL);
   assign pop_valid  = (count_ff != COUNT_EMPTY);
   assign pop_data   = head_ff;

   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;

   assign head_from_push = push && ((count_ff == COUNT_EMPTY) ||
                                    ((count_ff == COUNT_ONE) && pop));
   assign head_from_skid = pop && (count_ff == COUNT_FULL);
   assign skid_from_push = push && (((count_ff == COUNT_ONE) && !pop) ||
                                    ((count_ff == COUNT_FULL) && pop));

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_EMPTY;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_from_push) begin
         head_ff <= push_data;
      end else if (head_from_skid) begin
         head_ff <= skid_ff;
      end
      if (skid_from_push) begin
         skid_ff <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/line_rasterizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// A tick beat's pixel is registered into the result queue and leaves on rsp_ from its head register.
// Throughput: one beat per cycle while req_tready is high, start or tick; a start gives no pixel.
// The Bresenham step and the offset multiply sit between the line state and the result queue.
// req_tready drops only when both result queue entries are held, even if rsp_ takes one that cycle.
// Reset is synchronous: it ends any line, empties the result queue and loads
// max_col 639, max_row 479 and row_stride 640.
module line_rasterizer_core #(
   parameter int unsigned COORD_WIDTH = lrast_pkg::COORD_WIDTH_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,

   // Input beats.
   input  wire logic req_tvalid,
   output logic      req_tready,
   // tdata from the lowest bit: start_col, start_row, end_col, end_row, color, zero fill
   input  wire logic [lrast_pkg::pad_to_bytes(4 * (COORD_WIDTH + 1) +
                                              lrast_pkg::COLOR_WIDTH) - 1:0] req_tdata,
   // tuser: kind (start or tick)
   input  wire logic req_tuser,

   // Result beats.
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // tdata from the lowest bit: pixel_col, pixel_row, colour, byte_offset, zero fill
   output logic [lrast_pkg::pad_to_bytes(2 * COORD_WIDTH + lrast_pkg::COLOR_WIDTH +
                                         lrast_pkg::OFFSET_WIDTH) - 1:0] rsp_tdata,
   // tlast: final pixel of the line
   output logic      rsp_tlast,

   // Register writes.
   input  wire logic                                    csr_wr_en,
   input  wire logic [lrast_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [COORD_WIDTH:0]                    csr_wdata
);

   localparam int unsigned IN_W      = COORD_WIDTH + 1;
   localparam int unsigned STRIDE_W  = COORD_WIDTH + 1;
   localparam int unsigned ERR_W     = COORD_WIDTH + 3;
   localparam int unsigned IDX_W     = COORD_WIDTH + 1;
   localparam int unsigned COLOR_W   = lrast_pkg::COLOR_WIDTH;
   localparam int unsigned OFFSET_W  = lrast_pkg::OFFSET_WIDTH;
   localparam int unsigned RSP_BITS  = 2 * COORD_WIDTH + COLOR_W + OFFSET_W;
   localparam int unsigned RSP_TDATA_WIDTH = lrast_pkg::pad_to_bytes(RSP_BITS);
   localparam int unsigned WORD_W    = RSP_BITS + 1;
   localparam int unsigned PROD_W    = COORD_WIDTH + STRIDE_W;
   localparam int unsigned SUM_W     = PROD_W + 1;
   localparam int unsigned OFF_EXT_W = (SUM_W + 1 > OFFSET_W) ? SUM_W + 1 : OFFSET_W;

   // Clamps a signed endpoint coordinate into 0..hi.
   function automatic logic [COORD_WIDTH-1:0] clamp_coord(
      input logic signed [IN_W-1:0]  v,
      input logic [COORD_WIDTH-1:0]  hi
   );
      logic [COORD_WIDTH-1:0] mag;
      mag = v[COORD_WIDTH-1:0];
      if (v[IN_W-1]) begin
         clamp_coord = '0;
      end else if (mag > hi) begin
         clamp_coord = hi;
      end else begin
         clamp_coord = mag;
      end
   endfunction

   // Sign-extends a step to coordinate width so that it wraps like the state.
   function automatic logic [COORD_WIDTH-1:0] step_delta(input lrast_pkg::step_type s);
      step_delta = {{(COORD_WIDTH - 2){s[1]}}, s};
   endfunction

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [COORD_WIDTH-1:0] max_col_ff;
   logic [COORD_WIDTH-1:0] max_row_ff;
   logic [STRIDE_W-1:0]    row_stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_col_ff    <= COORD_WIDTH'(lrast_pkg::MAX_COL_RESET);
         max_row_ff    <= COORD_WIDTH'(lrast_pkg::MAX_ROW_RESET);
         row_stride_ff <= STRIDE_W'(lrast_pkg::ROW_STRIDE_RESET);
      end else if (csr_wr_en) begin
         case (csr_index)
            lrast_pkg::CSR_MAX_COL: begin
               max_col_ff <= csr_wdata[COORD_WIDTH-1:0];
            end
            lrast_pkg::CSR_MAX_ROW: begin
               max_row_ff <= csr_wdata[COORD_WIDTH-1:0];
            end
            lrast_pkg::CSR_ROW_STRIDE: begin
               row_stride_ff <= csr_wdata;
            end
            default: begin
               // Indexes past the register list are dropped.
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Input beat decode
   // ------------------------------------------------------------------
   logic                    accept;
   logic                    is_start;
   logic signed [IN_W-1:0]  start_col;
   logic signed [IN_W-1:0]  start_row;
   logic signed [IN_W-1:0]  end_col;
   logic signed [IN_W-1:0]  end_row;
   logic [COLOR_W-1:0]      color;

   assign accept    = req_tvalid && req_tready;
   assign is_start  = (req_tuser == lrast_pkg::KIND_START);
   assign start_col = req_tdata[IN_W-1:0];
   assign start_row = req_tdata[2*IN_W-1:IN_W];
   assign end_col   = req_tdata[3*IN_W-1:2*IN_W];
   assign end_row   = req_tdata[4*IN_W-1:3*IN_W];
   assign color     = req_tdata[4*IN_W+COLOR_W-1:4*IN_W];

   // ------------------------------------------------------------------
   // Line set-up for a start beat: clamp the endpoints, take the absolute
   // deltas and step signs, and pick the major axis. On equal deltas the
   // column stays the major axis.
   // ------------------------------------------------------------------
   logic [COORD_WIDTH-1:0] c1;
   logic [COORD_WIDTH-1:0] r1;
   logic [COORD_WIDTH-1:0] c2;
   logic [COORD_WIDTH-1:0] r2;
   logic [COORD_WIDTH-1:0] dc;
   logic [COORD_WIDTH-1:0] dr;
   lrast_pkg::step_type    col_step_new;
   lrast_pkg::step_type    row_step_new;
   logic                   swap_new;
   logic [COORD_WIDTH-1:0] major_new;
   logic [COORD_WIDTH-1:0] minor_new;
   logic [ERR_W-1:0]       error_new;

   assign c1 = clamp_coord(start_col, max_col_ff);
   assign r1 = clamp_coord(start_row, max_row_ff);
   assign c2 = clamp_coord(end_col, max_col_ff);
   assign r2 = clamp_coord(end_row, max_row_ff);

   always_comb begin
      if (c2 > c1) begin
         dc           = c2 - c1;
         col_step_new = lrast_pkg::STEP_POS;
      end else if (c2 < c1) begin
         dc           = c1 - c2;
         col_step_new = lrast_pkg::STEP_NEG;
      end else begin
         dc           = '0;
         col_step_new = lrast_pkg::STEP_ZERO;
      end
      if (r2 > r1) begin
         dr           = r2 - r1;
         row_step_new = lrast_pkg::STEP_POS;
      end else if (r2 < r1) begin
         dr           = r1 - r2;
         row_step_new = lrast_pkg::STEP_NEG;
      end else begin
         dr           = '0;
         row_step_new = lrast_pkg::STEP_ZERO;
      end
   end

   assign swap_new  = (dr > dc);
   assign major_new = swap_new ? dr : dc;
   assign minor_new = swap_new ? dc : dr;
   // 2 * minor - major, held signed in three bits more than the coordinate width.
   assign error_new = {2'b00, minor_new, 1'b0} - {3'b000, major_new};

   // ------------------------------------------------------------------
   // Line state
   // ------------------------------------------------------------------
   logic                   active_ff,       active_in;
   logic [COORD_WIDTH-1:0] cur_col_ff,      cur_col_in;
   logic [COORD_WIDTH-1:0] cur_row_ff,      cur_row_in;
   logic [ERR_W-1:0]       error_ff,        error_in;
   logic [COORD_WIDTH-1:0] major_len_ff,    major_len_in;
   logic [COORD_WIDTH-1:0] minor_len_ff,    minor_len_in;
   lrast_pkg::step_type    col_step_ff,     col_step_in;
   lrast_pkg::step_type    row_step_ff,     row_step_in;
   logic                   swapped_ff,      swapped_in;
   logic [IDX_W-1:0]       pixel_index_ff,  pixel_index_in;
   logic [COLOR_W-1:0]     line_color_ff,   line_color_in;

   // ------------------------------------------------------------------
   // Pixel step for a tick beat. The current pixel goes out as it stands;
   // the state then moves one pixel along the major axis, and along the
   // minor axis as well when the error term is not negative.
   // ------------------------------------------------------------------
   logic                   emit;
   logic                   is_last;
   logic                   error_nonneg;
   logic                   col_adv;
   logic                   row_adv;
   logic [ERR_W-1:0]       two_minor;
   logic [ERR_W-1:0]       two_major;
   logic [ERR_W-1:0]       error_stepped;
   logic [COORD_WIDTH-1:0] col_stepped;
   logic [COORD_WIDTH-1:0] row_stepped;

   assign emit          = accept && !is_start && active_ff;
   assign is_last       = (pixel_index_ff == {1'b0, major_len_ff});
   assign error_nonneg  = !error_ff[ERR_W-1];
   assign col_adv       = swapped_ff ? error_nonneg : 1'b1;
   assign row_adv       = swapped_ff ? 1'b1 : error_nonneg;
   assign two_minor     = {2'b00, minor_len_ff, 1'b0};
   assign two_major     = {2'b00, major_len_ff, 1'b0};
   assign error_stepped = error_ff + two_minor - (error_nonneg ? two_major : '0);
   assign col_stepped   = cur_col_ff + (col_adv ? step_delta(col_step_ff) : '0);
   assign row_stepped   = cur_row_ff + (row_adv ? step_delta(row_step_ff) : '0);

   always_comb begin
      active_in      = active_ff;
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      error_in       = error_ff;
      major_len_in   = major_len_ff;
      minor_len_in   = minor_len_ff;
      col_step_in    = col_step_ff;
      row_step_in    = row_step_ff;
      swapped_in     = swapped_ff;
      pixel_index_in = pixel_index_ff;
      line_color_in  = line_color_ff;
      if (accept && is_start) begin
         // A new line replaces whatever line is still running.
         active_in      = 1'b1;
         cur_col_in     = c1;
         cur_row_in     = r1;
         error_in       = error_new;
         major_len_in   = major_new;
         minor_len_in   = minor_new;
         col_step_in    = col_step_new;
         row_step_in    = row_step_new;
         swapped_in     = swap_new;
         pixel_index_in = '0;
         line_color_in  = color;
      end else if (emit) begin
         cur_col_in     = col_stepped;
         cur_row_in     = row_stepped;
         error_in       = error_stepped;
         pixel_index_in = pixel_index_ff + IDX_W'(1);
         if (is_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_col_ff     <= cur_col_in;
      cur_row_ff     <= cur_row_in;
      error_ff       <= error_in;
      major_len_ff   <= major_len_in;
      minor_len_ff   <= minor_len_in;
      col_step_ff    <= col_step_in;
      row_step_ff    <= row_step_in;
      swapped_ff     <= swapped_in;
      pixel_index_ff <= pixel_index_in;
      line_color_ff  <= line_color_in;
   end

   // ------------------------------------------------------------------
   // Byte offset of the current pixel: (row * stride + col) * 2, wrapped to
   // the offset width.
   // ------------------------------------------------------------------
   logic [PROD_W-1:0]    offset_prod;
   logic [SUM_W-1:0]     offset_sum;
   logic [OFF_EXT_W-1:0] offset_ext;
   logic [OFFSET_W-1:0]  byte_offset;

   assign offset_prod = PROD_W'(cur_row_ff) * PROD_W'(row_stride_ff);
   assign offset_sum  = SUM_W'(offset_prod) + SUM_W'(cur_col_ff);
   assign offset_ext  = OFF_EXT_W'({offset_sum, 1'b0});
   assign byte_offset = offset_ext[OFFSET_W-1:0];

   // ------------------------------------------------------------------
   // Result queue
   // ------------------------------------------------------------------
   logic [WORD_W-1:0] push_word;
   logic [WORD_W-1:0] pop_word;

   assign push_word = {is_last, byte_offset, line_color_ff, cur_row_ff, cur_col_ff};

   lrast_out_queue #(
      .DATA_WIDTH (WORD_W)
   ) u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (emit),
      .push_data  (push_word),
      .push_ready (req_tready),
      .pop_valid  (rsp_tvalid),
      .pop_ready  (rsp_tready),
      .pop_data   (pop_word)
   );

   assign rsp_tdata = RSP_TDATA_WIDTH'(pop_word[RSP_BITS-1:0]);
   assign rsp_tlast = pop_word[RSP_BITS];

endmodule

`default_nettype wire

FILE: hw/rtl/lrast_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module lrast_checker #(
   parameter int unsigned RSP_TDATA_WIDTH = 8
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_tvalid,
   input wire logic                       req_tready,
   input wire logic                       req_tuser,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic                       rsp_tlast,
   input wire logic [RSP_TDATA_WIDTH-1:0] rsp_tdata
);

   // A stalled result beat holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // A result only appears the cycle after a tick beat was taken.
   a_rsp_from_tick: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready &&
                                  (req_tuser == lrast_pkg::KIND_TICK)))
      else $error("result beat without a preceding tick");

   // Input back-pressure only while results are waiting.
   a_ready_low_needs_backlog: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result pending");

   // Reset empties the result side.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind line_rasterizer_core lrast_checker #(
   .RSP_TDATA_WIDTH (RSP_TDATA_WIDTH)
) u_lrast_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tlast  (rsp_tlast),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
